### rtl/core/trd_pkg.sv
// ----------------------------------------------------------------------------
// trd_pkg
// Shared types and constants of the top-region discriminant core.
// ----------------------------------------------------------------------------
`default_nettype none

package trd_pkg;

	localparam int ET_W      = 10;
	localparam int SUM_W     = 14;
	localparam int POS_W     = 4;
	localparam int CNT_W     = 5;
	localparam int SPAN_W    = 6;

	localparam int MAX_REGIONS_DEF = 16;
	localparam logic [CNT_W-1:0] N_REGIONS_RST = 5'd4;

	localparam logic [SUM_W-1:0] SUM_CAP = '1;
	localparam logic [CNT_W-1:0] CNT_CAP = '1;

	// extents are seeded outside the window so an empty run passes
	localparam logic signed [POS_W-1:0] EXT_MAX_SEED = -4'sd5;
	localparam logic signed [POS_W-1:0] EXT_MIN_SEED = 4'sd5;

	localparam int IN_DATA_W  = 32;
	localparam int OUT_DATA_W = 64;

	// region word, first member in the top bits
	typedef struct packed {
		logic                    mip;
		logic signed [POS_W-1:0] phi_pos;
		logic signed [POS_W-1:0] eta_pos;
		logic [ET_W-1:0]         ecal_et;
		logic [ET_W-1:0]         et;
	} item_t;

	typedef struct packed {
		logic [ET_W-1:0]  lowest_ecal_et;
		logic [ET_W-1:0]  lowest_et;
		logic [CNT_W-1:0] region_count;
		logic [CNT_W-1:0] mip_count;
		logic             pattern_pass;
		logic [SUM_W-1:0] total_ecal_et;
		logic [SUM_W-1:0] total_et;
	} res_t;

	localparam int ITEM_W = $bits(item_t);
	localparam int RES_W  = $bits(res_t);

endpackage

`default_nettype wire

### rtl/core/trd_accum.sv
// ----------------------------------------------------------------------------
// trd_accum
// Per-collection accumulator: acceptance, sums, counts, extents and the
// pattern test, with the result formed in the same cycle as the last region.
// ----------------------------------------------------------------------------
`default_nettype none

module trd_accum (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      step,
	input  wire trd_pkg::item_t            item,
	input  wire logic                      last_region,
	input  wire logic [trd_pkg::CNT_W-1:0] limit,
	output trd_pkg::res_t                  res
);
	import trd_pkg::*;

	logic [CNT_W-1:0]        taken_q;
	logic                    stopped_q;
	logic [SUM_W-1:0]        sum_et_q;
	logic [SUM_W-1:0]        sum_ecal_q;
	logic [CNT_W-1:0]        mip_q;
	logic signed [POS_W-1:0] eta_max_q;
	logic signed [POS_W-1:0] eta_min_q;
	logic signed [POS_W-1:0] phi_max_q;
	logic signed [POS_W-1:0] phi_min_q;
	logic signed [POS_W-1:0] first_eta_q;
	logic signed [POS_W-1:0] first_phi_q;
	logic                    pair_q;
	logic [ET_W-1:0]         last_et_q;
	logic [ET_W-1:0]         last_ecal_q;

	logic                    take;
	logic signed [POS_W-1:0] eta;
	logic signed [POS_W-1:0] phi;
	logic [CNT_W-1:0]        taken_n;
	logic                    stopped_n;
	logic [SUM_W:0]          sum_et_raw;
	logic [SUM_W:0]          sum_ecal_raw;
	logic [CNT_W:0]          mip_raw;
	logic [SUM_W-1:0]        sum_et_n;
	logic [SUM_W-1:0]        sum_ecal_n;
	logic [CNT_W-1:0]        mip_n;
	logic signed [POS_W-1:0] eta_max_n;
	logic signed [POS_W-1:0] eta_min_n;
	logic signed [POS_W-1:0] phi_max_n;
	logic signed [POS_W-1:0] phi_min_n;
	logic signed [POS_W-1:0] first_eta_n;
	logic signed [POS_W-1:0] first_phi_n;
	logic                    pair_n;
	logic [ET_W-1:0]         last_et_n;
	logic [ET_W-1:0]         last_ecal_n;
	logic signed [SPAN_W-1:0] eta_span;
	logic signed [SPAN_W-1:0] phi_span;
	logic                    compact;

	always_comb begin
		eta  = item.eta_pos;
		phi  = item.phi_pos;
		take = !stopped_q && (item.et != '0) && (taken_q < limit);

		sum_et_raw   = {1'b0, sum_et_q} + (SUM_W+1)'(item.et);
		sum_ecal_raw = {1'b0, sum_ecal_q} + (SUM_W+1)'(item.ecal_et);
		mip_raw      = {1'b0, mip_q} + (CNT_W+1)'(item.mip);

		stopped_n   = stopped_q || !take;
		taken_n     = taken_q;
		sum_et_n    = sum_et_q;
		sum_ecal_n  = sum_ecal_q;
		mip_n       = mip_q;
		eta_max_n   = eta_max_q;
		eta_min_n   = eta_min_q;
		phi_max_n   = phi_max_q;
		phi_min_n   = phi_min_q;
		first_eta_n = first_eta_q;
		first_phi_n = first_phi_q;
		pair_n      = pair_q;
		last_et_n   = last_et_q;
		last_ecal_n = last_ecal_q;

		if (take) begin
			taken_n     = taken_q + 1'b1;
			sum_et_n    = sum_et_raw[SUM_W] ? SUM_CAP : sum_et_raw[SUM_W-1:0];
			sum_ecal_n  = sum_ecal_raw[SUM_W] ? SUM_CAP : sum_ecal_raw[SUM_W-1:0];
			mip_n       = mip_raw[CNT_W] ? CNT_CAP : mip_raw[CNT_W-1:0];
			if (eta > eta_max_q) eta_max_n = eta;
			if (eta < eta_min_q) eta_min_n = eta;
			if (phi > phi_max_q) phi_max_n = phi;
			if (phi < phi_min_q) phi_min_n = phi;
			last_et_n   = item.et;
			last_ecal_n = item.ecal_et;
			if (taken_q == CNT_W'(0)) begin
				first_eta_n = eta;
				first_phi_n = phi;
			end else if (taken_q == CNT_W'(1)) begin
				pair_n = (eta == first_eta_q) || (phi == first_phi_q);
			end
		end

		eta_span = SPAN_W'(eta_max_n) - SPAN_W'(eta_min_n);
		phi_span = SPAN_W'(phi_max_n) - SPAN_W'(phi_min_n);
		compact  = (eta_span <= 6'sd1) && (phi_span <= 6'sd1)
			&& !((taken_n == CNT_W'(2)) && !pair_n);

		res.total_et       = sum_et_n;
		res.total_ecal_et  = sum_ecal_n;
		res.pattern_pass   = (taken_n == CNT_W'(1)) || compact;
		res.mip_count      = mip_n;
		res.region_count   = taken_n;
		res.lowest_et      = last_et_n;
		res.lowest_ecal_et = last_ecal_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taken_q     <= '0;
			stopped_q   <= 1'b0;
			sum_et_q    <= '0;
			sum_ecal_q  <= '0;
			mip_q       <= '0;
			eta_max_q   <= EXT_MAX_SEED;
			eta_min_q   <= EXT_MIN_SEED;
			phi_max_q   <= EXT_MAX_SEED;
			phi_min_q   <= EXT_MIN_SEED;
			first_eta_q <= '0;
			first_phi_q <= '0;
			pair_q      <= 1'b1;
			last_et_q   <= '0;
			last_ecal_q <= '0;
		end else if (step) begin
			if (last_region) begin
				// collection done: back to the seeded state
				taken_q     <= '0;
				stopped_q   <= 1'b0;
				sum_et_q    <= '0;
				sum_ecal_q  <= '0;
				mip_q       <= '0;
				eta_max_q   <= EXT_MAX_SEED;
				eta_min_q   <= EXT_MIN_SEED;
				phi_max_q   <= EXT_MAX_SEED;
				phi_min_q   <= EXT_MIN_SEED;
				first_eta_q <= '0;
				first_phi_q <= '0;
				pair_q      <= 1'b1;
				last_et_q   <= '0;
				last_ecal_q <= '0;
			end else begin
				taken_q     <= taken_n;
				stopped_q   <= stopped_n;
				sum_et_q    <= sum_et_n;
				sum_ecal_q  <= sum_ecal_n;
				mip_q       <= mip_n;
				eta_max_q   <= eta_max_n;
				eta_min_q   <= eta_min_n;
				phi_max_q   <= phi_max_n;
				phi_min_q   <= phi_min_n;
				first_eta_q <= first_eta_n;
				first_phi_q <= first_phi_n;
				pair_q      <= pair_n;
				last_et_q   <= last_et_n;
				last_ecal_q <= last_ecal_n;
			end
		end
	end

endmodule

`default_nettype wire

### rtl/core/top_region_discriminant_core.sv
// ----------------------------------------------------------------------------
// top_region_discriminant_core
// Accepts regions of a collection, keeps energy sums, MIP count and extent,
// and emits one summary word on the region flagged tlast.
// ----------------------------------------------------------------------------
// One region is taken every clock cycle while the input does not stall. A region
// is captured in the input register, is folded into the accumulator and, if it
// carries tlast, its summary is loaded into the output register, which drives
// m_axis_tvalid. The input stalls only while a summary waits in the output
// register and the next region in line is itself a last one.
// n_regions is applied at the following region and must be written between
// collections; values above MAX_REGIONS are clamped.
`default_nettype none

module top_region_discriminant_core #(
	parameter int MAX_REGIONS = trd_pkg::MAX_REGIONS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// et[9:0], ecal_et[19:10], eta_pos[23:20], phi_pos[27:24], mip[28]
	input  wire logic [trd_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	input  wire logic                           s_axis_tlast,
	input  wire logic                           s_axis_tvalid,
	output logic                                s_axis_tready,
	// total_et[13:0], total_ecal_et[27:14], pattern_pass[28],
	// mip_count[33:29], region_count[38:34], lowest_et[48:39],
	// lowest_ecal_et[58:49]
	output logic [trd_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
	output logic                                m_axis_tvalid,
	input  wire logic                           m_axis_tready,
	input  wire logic [trd_pkg::CNT_W-1:0]      cfg_data,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready
);
	import trd_pkg::*;

	localparam int LIM_CAP = (MAX_REGIONS > 31) ? 31 : MAX_REGIONS;

	logic [CNT_W-1:0] n_regions_q;
	logic [CNT_W-1:0] limit;

	item_t item_s1;
	logic  last_s1;
	logic  valid_s1;
	logic  step;

	res_t  res;
	res_t  out_q;
	logic  out_valid_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_regions_q <= N_REGIONS_RST;
		end else if (cfg_valid) begin
			n_regions_q <= cfg_data;
		end
	end

	assign limit = (int'(n_regions_q) > LIM_CAP) ? CNT_W'(LIM_CAP) : n_regions_q;

	// a last region needs the output register free or draining
	assign step = valid_s1 && (!last_s1 || !out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1 <= item_t'(s_axis_tdata[ITEM_W-1:0]);
			last_s1 <= s_axis_tlast;
		end
	end

	trd_accum u_accum (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.item        (item_s1),
		.last_region (last_s1),
		.limit       (limit),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && last_s1) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {(OUT_DATA_W-RES_W)'(0), out_q};

endmodule

`default_nettype wire

### rtl/core/trd_checker.sv
// ----------------------------------------------------------------------------
// trd_checker
// Port-level checks on the top-region discriminant core, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module trd_checker #(
	parameter int MAX_REGIONS = trd_pkg::MAX_REGIONS_DEF
) (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic [trd_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input wire logic                           m_axis_tvalid,
	input wire logic                           m_axis_tready
);
	import trd_pkg::*;

	res_t r;
	assign r = res_t'(m_axis_tdata[RES_W-1:0]);

	// a stalled summary word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("summary word changed while stalled");

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> int'(r.region_count) <= MAX_REGIONS
			&& r.mip_count <= r.region_count)
		else $error("region or MIP count out of range");

	a_single_pass: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && r.region_count <= 5'd1 |-> r.pattern_pass)
		else $error("single or empty collection failed pattern");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && r.region_count == '0 |->
			r.total_et == '0 && r.lowest_et == '0 && r.lowest_ecal_et == '0)
		else $error("empty collection reports energy");

	a_sum_ge_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> r.total_et >= SUM_W'(r.lowest_et)
			&& r.total_ecal_et >= SUM_W'(r.lowest_ecal_et))
		else $error("sum below last region energy");

endmodule

bind top_region_discriminant_core trd_checker #(.MAX_REGIONS(MAX_REGIONS)) u_trd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready)
);

`default_nettype wire

### tb/sv/top_region_discriminant_core_tb.sv
// ----------------------------------------------------------------------------
// top_region_discriminant_core_tb
// Self-checking bench for the top-region discriminant core. Regions are sent
// as collections over the input stream and each summary word is checked
// against an in-bench model of the accumulator. A short directed sequence
// covers field extremes and the corner cases (empty run, zero-energy stop,
// limit of zero, clamped limit, pair alignment). A random phase follows,
// mostly compact collections with random content, mixed with wide and broken
// ones, under changing limits and random idling on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module top_region_discriminant_core_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import trd_pkg::*;

	localparam int REGION_CAP   = MAX_REGIONS_DEF;
	localparam int TARGET_WORDS = 1700;
	localparam int DRAIN_CYCLES = 6;

	// Accumulator model and store of pending summaries
	class summary_board;
		logic [CNT_W-1:0]        limit_q;
		logic [CNT_W-1:0]        taken;
		bit                      stopped;
		logic [SUM_W-1:0]        sum_et;
		logic [SUM_W-1:0]        sum_ecal;
		logic [CNT_W-1:0]        mip_tot;
		logic signed [POS_W-1:0] eta_hi;
		logic signed [POS_W-1:0] eta_lo;
		logic signed [POS_W-1:0] phi_hi;
		logic signed [POS_W-1:0] phi_lo;
		logic signed [POS_W-1:0] eta_first;
		logic signed [POS_W-1:0] phi_first;
		bit                      aligned;
		logic [ET_W-1:0]         tail_et;
		logic [ET_W-1:0]         tail_ecal;
		res_t                    summary_q[$];
		int                      errors;
		int                      checked;

		function new();
			limit_q = N_REGIONS_RST;
			errors  = 0;
			checked = 0;
			clear();
		endfunction

		function void clear();
			taken     = '0;
			stopped   = 1'b0;
			sum_et    = '0;
			sum_ecal  = '0;
			mip_tot   = '0;
			eta_hi    = EXT_MAX_SEED;
			eta_lo    = EXT_MIN_SEED;
			phi_hi    = EXT_MAX_SEED;
			phi_lo    = EXT_MIN_SEED;
			eta_first = '0;
			phi_first = '0;
			aligned   = 1'b1;
			tail_et   = '0;
			tail_ecal = '0;
		endfunction

		function void set_limit(logic [CNT_W-1:0] v);
			limit_q = v;
		endfunction

		function logic [SUM_W-1:0] sat_sum(logic [SUM_W-1:0] a, logic [ET_W-1:0] b);
			int s;
			s = int'(a) + int'(b);
			return (s > int'(SUM_CAP)) ? SUM_CAP : s[SUM_W-1:0];
		endfunction

		// one accepted region word; a last one queues its summary
		function void note_region(item_t r, bit last);
			int   cap;
			bit   pass;
			res_t s;
			cap  = (int'(limit_q) > REGION_CAP) ? REGION_CAP : int'(limit_q);
			if (!stopped) begin
				if (r.et == '0 || int'(taken) >= cap) begin
					stopped = 1'b1;
				end else begin
					if (taken == 0) begin
						eta_first = r.eta_pos;
						phi_first = r.phi_pos;
					end else if (taken == 1) begin
						aligned = (r.eta_pos == eta_first) || (r.phi_pos == phi_first);
					end
					taken    = taken + 1'b1;
					sum_et   = sat_sum(sum_et, r.et);
					sum_ecal = sat_sum(sum_ecal, r.ecal_et);
					if (r.mip && mip_tot != CNT_CAP)
						mip_tot = mip_tot + 1'b1;
					if (r.eta_pos > eta_hi) eta_hi = r.eta_pos;
					if (r.eta_pos < eta_lo) eta_lo = r.eta_pos;
					if (r.phi_pos > phi_hi) phi_hi = r.phi_pos;
					if (r.phi_pos < phi_lo) phi_lo = r.phi_pos;
					tail_et   = r.et;
					tail_ecal = r.ecal_et;
				end
			end
			if (last) begin
				if (taken == 1) begin
					pass = 1'b1;
				end else begin
					pass = (int'(phi_hi) - int'(phi_lo) <= 1) &&
						(int'(eta_hi) - int'(eta_lo) <= 1);
					if (pass && taken == 2 && !aligned)
						pass = 1'b0;
				end
				s.total_et       = sum_et;
				s.total_ecal_et  = sum_ecal;
				s.pattern_pass   = pass;
				s.mip_count      = mip_tot;
				s.region_count   = taken;
				s.lowest_et      = tail_et;
				s.lowest_ecal_et = tail_ecal;
				summary_q.insert(summary_q.size(), s);
				clear();
			end
		endfunction

		function void compare_field(string name, int e, int a);
			if (e != a) begin
				errors++;
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, e, a);
			end
		endfunction

		function void check_summary(res_t got);
			res_t e;
			if (summary_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected summary word, expected none, got %h",
					$time, got);
			end else begin
				e = summary_q.pop_front();
				checked++;
				compare_field("total_et", e.total_et, got.total_et);
				compare_field("total_ecal_et", e.total_ecal_et, got.total_ecal_et);
				compare_field("pattern_pass", e.pattern_pass, got.pattern_pass);
				compare_field("mip_count", e.mip_count, got.mip_count);
				compare_field("region_count", e.region_count, got.region_count);
				compare_field("lowest_et", e.lowest_et, got.lowest_et);
				compare_field("lowest_ecal_et", e.lowest_ecal_et, got.lowest_ecal_et);
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic                  s_axis_tlast = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [CNT_W-1:0]      cfg_data = '0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;

	summary_board sb = new();
	bit           no_idle = 1'b0;
	int           n_used = 0;
	int           n_collections = 0;
	int           n_cfg = 0;

	top_region_discriminant_core #(
		.MAX_REGIONS(REGION_CAP)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.cfg_data(cfg_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("%0t: timeout", $time);
		$display("Test completed with failures");
		$finish;
	end

	// mostly short gaps, now and then a long one
	function int pick_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// output side back-pressure
	initial begin
		int n;
		wait (arst_n);
		forever begin
			if (no_idle) begin
				m_axis_tready <= 1'b1;
				@(posedge clk);
			end else begin
				n = pick_gap();
				if (n > 0) begin
					m_axis_tready <= 1'b0;
					repeat (n) @(posedge clk);
				end
				m_axis_tready <= 1'b1;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_summary(res_t'(m_axis_tdata[RES_W-1:0]));
	end

	task automatic send_region(int et, int ecal, int eta, int phi, bit mip, bit last);
		item_t r;
		int    n;
		r.et      = et[ET_W-1:0];
		r.ecal_et = ecal[ET_W-1:0];
		r.eta_pos = eta[POS_W-1:0];
		r.phi_pos = phi[POS_W-1:0];
		r.mip     = mip;
		n = pick_gap();
		if (n > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		s_axis_tdata  <= {{(IN_DATA_W-ITEM_W){1'b0}}, r};
		s_axis_tlast  <= last;
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_region(r, last);
		n_used++;
	endtask

	// wait until every summary is out and the pipeline has drained
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (sb.summary_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(int v);
		settle();
		cfg_data  <= v[CNT_W-1:0];
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.set_limit(v[CNT_W-1:0]);
		n_cfg++;
	endtask

	task automatic send_collection();
		int len;
		int ce;
		int cp;
		int et;
		int eta;
		int phi;
		bit compact;
		len     = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
		compact = $urandom_range(0, 9) < 6;
		ce      = int'($urandom_range(0, 6)) - 3;
		cp      = int'($urandom_range(0, 6)) - 3;
		for (int i = 0; i < len; i++) begin
			if (compact) begin
				eta = ce + int'($urandom_range(0, 1));
				phi = cp + int'($urandom_range(0, 1));
				et  = ($urandom_range(0, 39) == 0) ? 0 : $urandom_range(1, 1023);
			end else begin
				eta = int'($urandom_range(0, 15)) - 8;
				phi = int'($urandom_range(0, 15)) - 8;
				et  = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(0, 1023);
			end
			send_region(et, $urandom_range(0, 1023), eta, phi, bit'($urandom_range(0, 1)),
				i == len - 1);
		end
		n_collections++;
	endtask

	initial begin
		int lim;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// limit left at its reset value of four
		send_region(1023, 1023, 4, -4, 1, 1);
		send_region(0, 1023, 0, 0, 1, 1);        // empty run
		send_region(10, 20, 0, 0, 0, 0);         // diagonal pair fails
		send_region(11, 21, 1, 1, 1, 1);
		send_region(12, 0, -1, 2, 0, 0);         // pair sharing eta
		send_region(13, 0, -1, 3, 0, 1);
		send_region(5, 6, 0, 0, 1, 0);           // zero energy stops the run
		send_region(0, 6, 0, 0, 1, 0);
		send_region(7, 8, 3, 3, 0, 0);
		send_region(9, 9, -3, -3, 1, 1);
		send_region(100, 1, -8, 7, 0, 0);        // fifth region over the limit
		send_region(200, 2, 7, -8, 1, 0);
		send_region(300, 3, 0, 0, 0, 0);
		send_region(400, 4, 0, 0, 1, 0);
		send_region(500, 5, 1, 1, 1, 1);
		write_limit(0);
		send_region(50, 50, 0, 0, 1, 0);
		send_region(60, 60, 1, 0, 1, 1);
		write_limit(1);
		send_region(70, 0, 2, 2, 0, 0);
		send_region(80, 1, -4, 4, 1, 1);
		write_limit(31);                         // clamped to the cap
		send_region(1, 1023, 0, 0, 0, 1);
		send_region(33, 44, 0, 0, 1, 0);         // compact triple
		send_region(55, 66, 1, 0, 0, 0);
		send_region(77, 88, 1, 1, 1, 1);

		n_used = 0;
		while (n_used < TARGET_WORDS) begin
			if (n_collections % 12 == 0) begin
				case ($urandom_range(0, 7))
					0: lim = 0;
					1: lim = 1;
					2: lim = 2;
					3: lim = REGION_CAP;
					4: lim = REGION_CAP + 1;
					5: lim = 31;
					6: lim = $urandom_range(2, 5);
					default: lim = $urandom_range(0, 31);
				endcase
				write_limit(lim);
				no_idle = ($urandom_range(0, 4) == 0);
			end
			send_collection();
		end

		no_idle = 1'b0;
		settle();
		$display("Ran %0d random collections (%0d region words) across %0d limit writes;",
			n_collections, n_used, n_cfg);
		$display("%0d summary words checked with random idling on both sides.", sb.checked);
		if (sb.errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

`default_nettype wire
